[rtl/string_key_hash_table_probe_defines.svh]
// ----------------------------------------------------------------------------
// string_key_hash_table_probe_defines
// Assertion macros shared by the string key hash table probe.
// ----------------------------------------------------------------------------
`ifndef STRING_KEY_HASH_TABLE_PROBE_DEFINES_SVH
`define STRING_KEY_HASH_TABLE_PROBE_DEFINES_SVH
`ifndef SYNTHESIS
`define SKH_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SKH_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SKH_ASSERT(label, clk, rst_n, prop, msg)
`define SKH_ASSERT_RST(label, clk, prop, msg)
`endif
`endif

[rtl/skh_pkg.sv]
// ----------------------------------------------------------------------------
// skh_pkg
// Shared types and constants of the string key hash table probe.
// ----------------------------------------------------------------------------
package skh_pkg;

  localparam int unsigned TableEntries = 1024;
  localparam int unsigned KeyBytes     = 32;
  localparam int unsigned IndexBits    = 20;

  localparam logic [63:0] HashSeed = 64'd5381;

  localparam logic [2:0] StInserted = 3'd0;
  localparam logic [2:0] StFound    = 3'd1;
  localparam logic [2:0] StNotFound = 3'd2;
  localparam logic [2:0] StFull     = 3'd3;
  localparam logic [2:0] StTooLong  = 3'd4;

  typedef struct packed {
    logic        action;
    logic [7:0]  key_byte;
    logic        key_last;
    logic [19:0] rec_start;
    logic [19:0] group_count;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [19:0] found_start;
    logic [19:0] found_count;
    logic [9:0]  slot;
  } out_item_t;

endpackage

[rtl/string_key_hash_table_probe.sv]
// ----------------------------------------------------------------------------
// string_key_hash_table_probe
// Open addressed hash table with string keys and linear probing.
// ----------------------------------------------------------------------------
// Usage: key bytes enter on the input channel, one transaction each, with
// the action, the last flag and, on the last byte, the record fields. A
// byte that is not last gives no result. After reset a clear pass writes
// every slot free; no input is accepted meanwhile. The last byte starts an
// operation: the hash is reduced to a slot index in S_MOD (a mask when
// TABLE_ENTRIES is a power of two, else repeated compare and subtract),
// then the walk reads and decides on each slot (S_RD, S_CHK). An insert
// copies the key at one cycle a byte; a find compares each slot of matching
// length byte by byte, with a read (S_CMP_RD) and a compare (S_CMP) for
// each byte. One result goes out per key and is held in an output register
// while the receiver stalls; further key bytes are still taken meanwhile,
// but the next last byte waits until the result has left. Reset clears the
// pending key length, the hash and the output register.
// ----------------------------------------------------------------------------
`include "string_key_hash_table_probe_defines.svh"

module string_key_hash_table_probe #(
  parameter int unsigned TABLE_ENTRIES = skh_pkg::TableEntries,
  parameter int unsigned KEY_BYTES     = skh_pkg::KeyBytes,
  parameter int unsigned INDEX_BITS    = skh_pkg::IndexBits
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  skh_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output skh_pkg::out_item_t out_data_o
);

  localparam int unsigned SlotBits = $clog2(TABLE_ENTRIES);
  localparam int unsigned KeyBits  = $clog2(KEY_BYTES);
  localparam int unsigned KaBits   = (KeyBits > 0) ? KeyBits : 1;
  localparam int unsigned LenBits  = $clog2(KEY_BYTES + 1);
  localparam int unsigned CntBits  = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned HdrW     = 1 + LenBits + 2 * INDEX_BITS;
  localparam bit          EntriesPow2 = ((TABLE_ENTRIES & (TABLE_ENTRIES - 1)) == 0);
  localparam logic [64:0] DivTop = EntriesPow2 ? 65'(TABLE_ENTRIES) :
                                   (65'(TABLE_ENTRIES) << (64 - SlotBits));

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_MOD, S_RD, S_CHK, S_CMP_RD, S_CMP, S_COPY, S_DONE
  } state_e;

  state_e state_q;

  // Pending key, kept in flip-flops (read at a walking index).
  logic [7:0]         pkey_q [KEY_BYTES];
  logic [LenBits-1:0] plen_q;
  logic               ovf_q;
  logic               action_q;
  logic [INDEX_BITS-1:0] st_q, gc_q;

  logic [63:0] hash_next;
  logic        in_acc, byte_step, op_start;

  logic [SlotBits-1:0] idx_q;
  logic [CntBits-1:0]  n_q;
  logic [LenBits-1:0]  k_q;
  logic [63:0]         rem_q;
  logic [64:0]         div_q;
  logic [63:0]         rem_red;
  logic                mod_last;

  logic                out_valid_q;
  skh_pkg::out_item_t  out_q;

  // Header memory: used flag, length, start, count.
  logic                hdr_we;
  logic [SlotBits-1:0] hdr_addr;
  logic [HdrW-1:0]     hdr_wdata, hdr_rdata;
  logic                rd_used;
  logic [LenBits-1:0]  rd_len;
  logic [INDEX_BITS-1:0] rd_st, rd_gc;

  // Key byte memory.
  logic                          key_we;
  logic [SlotBits+KaBits-1:0]    key_addr;
  logic [7:0]                    key_rdata;

  assign in_stall_o = (state_q != S_IDLE) || (in_data_i.key_last && out_valid_q);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign byte_step  = in_acc;
  assign op_start   = in_acc && in_data_i.key_last;

  skh_hash u_hash (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .step_i  (byte_step),
    .clear_i (state_q == S_DONE),
    .byte_i  (in_data_i.key_byte),
    .next_o  (hash_next)
  );

  // Hash to slot index: a mask for a power of two table, otherwise one
  // compare and subtract of the shifted table size per cycle.
  assign rem_red  = EntriesPow2 ? (rem_q & 64'(TABLE_ENTRIES - 1)) :
                    (({1'b0, rem_q} >= div_q) ? (rem_q - div_q[63:0]) : rem_q);
  assign mod_last = EntriesPow2 || (div_q == 65'(TABLE_ENTRIES));

  assign {rd_used, rd_len, rd_st, rd_gc} = hdr_rdata;

  skh_mem #(.Depth(TABLE_ENTRIES), .Width(HdrW)) u_hdr (
    .clk_i   (clk_i),
    .we_i    (hdr_we),
    .addr_i  (hdr_addr),
    .wdata_i (hdr_wdata),
    .rdata_o (hdr_rdata)
  );

  skh_mem #(.Depth(TABLE_ENTRIES * (2 ** KaBits)), .Width(8)) u_key (
    .clk_i   (clk_i),
    .we_i    (key_we),
    .addr_i  (key_addr),
    .wdata_i (pkey_q[k_q[KaBits-1:0]]),
    .rdata_o (key_rdata)
  );

  // Memory port control.
  always_comb begin
    hdr_we    = 1'b0;
    hdr_addr  = idx_q;
    hdr_wdata = {1'b1, plen_q, st_q, gc_q};
    key_we    = 1'b0;
    key_addr  = {idx_q, k_q[KaBits-1:0]};
    case (state_q)
      S_CLEAR: begin
        hdr_we    = 1'b1;
        hdr_wdata = '0;
      end
      S_CHK: begin
        if (!action_q && !rd_used) begin
          hdr_we = 1'b1;
        end
      end
      S_COPY: begin
        key_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Pending key capture.
  always_ff @(posedge clk_i) begin
    if (byte_step && (plen_q < LenBits'(KEY_BYTES))) begin
      pkey_q[plen_q[KaBits-1:0]] <= in_data_i.key_byte;
    end
    if (op_start) begin
      action_q <= in_data_i.action;
      st_q     <= INDEX_BITS'(in_data_i.rec_start);
      gc_q     <= INDEX_BITS'(in_data_i.group_count);
      rem_q    <= hash_next;
      div_q    <= DivTop;
    end else if (state_q == S_MOD) begin
      rem_q    <= rem_red;
      div_q    <= div_q >> 1;
    end
  end

  // Control state, walk counters and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      plen_q      <= '0;
      ovf_q       <= 1'b0;
      idx_q       <= '0;
      n_q         <= '0;
      k_q         <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (byte_step) begin
        if (plen_q < LenBits'(KEY_BYTES)) begin
          plen_q <= plen_q + 1'b1;
        end else begin
          ovf_q <= 1'b1;
        end
      end
      case (state_q)
        S_CLEAR: begin
          if (idx_q == SlotBits'(TABLE_ENTRIES - 1)) begin
            idx_q   <= '0;
            state_q <= S_IDLE;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_IDLE: begin
          if (op_start) begin
            n_q     <= '0;
            k_q     <= '0;
            state_q <= S_MOD;
          end
        end
        S_MOD: begin
          if (ovf_q) begin
            out_q   <= '{status: skh_pkg::StTooLong, default: '0};
            state_q <= S_DONE;
          end else if (mod_last) begin
            idx_q   <= SlotBits'(rem_red);
            state_q <= S_RD;
          end
        end
        S_RD: begin
          if (n_q == CntBits'(TABLE_ENTRIES)) begin
            out_q   <= '{status: action_q ? skh_pkg::StNotFound : skh_pkg::StFull,
                         default: '0};
            state_q <= S_DONE;
          end else begin
            state_q <= S_CHK;
          end
        end
        S_CHK: begin
          k_q <= '0;
          if (!action_q) begin
            if (!rd_used) begin
              out_q   <= '{status: skh_pkg::StInserted, found_start: '0,
                           found_count: '0, slot: 10'(idx_q)};
              state_q <= (plen_q == '0) ? S_DONE : S_COPY;
            end else begin
              idx_q   <= (idx_q == SlotBits'(TABLE_ENTRIES - 1)) ? '0 : idx_q + 1'b1;
              n_q     <= n_q + 1'b1;
              state_q <= S_RD;
            end
          end else if (!rd_used) begin
            out_q   <= '{status: skh_pkg::StNotFound, default: '0};
            state_q <= S_DONE;
          end else if (rd_len == plen_q) begin
            out_q   <= '{status: skh_pkg::StFound,
                         found_start: 20'(rd_st), found_count: 20'(rd_gc),
                         slot: 10'(idx_q)};
            state_q <= (plen_q == '0) ? S_DONE : S_CMP_RD;
          end else begin
            idx_q   <= (idx_q == SlotBits'(TABLE_ENTRIES - 1)) ? '0 : idx_q + 1'b1;
            n_q     <= n_q + 1'b1;
            state_q <= S_RD;
          end
        end
        S_CMP_RD: begin
          state_q <= S_CMP;
        end
        S_CMP: begin
          if (key_rdata != pkey_q[k_q[KaBits-1:0]]) begin
            idx_q   <= (idx_q == SlotBits'(TABLE_ENTRIES - 1)) ? '0 : idx_q + 1'b1;
            n_q     <= n_q + 1'b1;
            k_q     <= '0;
            state_q <= S_RD;
          end else if (k_q + 1'b1 == plen_q) begin
            state_q <= S_DONE;
          end else begin
            k_q     <= k_q + 1'b1;
            state_q <= S_CMP_RD;
          end
        end
        S_COPY: begin
          k_q <= k_q + 1'b1;
          if (k_q + 1'b1 == plen_q) begin
            state_q <= S_DONE;
          end
        end
        S_DONE: begin
          out_valid_q <= 1'b1;
          plen_q      <= '0;
          ovf_q       <= 1'b0;
          state_q     <= S_IDLE;
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `SKH_ASSERT(a_no_accept_busy, clk_i, rst_ni, in_acc |-> state_q == S_IDLE, "accept while busy")
  `SKH_ASSERT(a_done_no_pending, clk_i, rst_ni, state_q == S_DONE |-> !out_valid_q, "result overrun")
  `SKH_ASSERT(a_hold, clk_i, rst_ni, out_valid_q && out_stall_i |=> out_valid_q && $stable(out_q), "stalled result changed")
  `SKH_ASSERT_RST(a_reset_clear, clk_i, !rst_ni |-> !out_valid_o, "output valid in reset")

endmodule

[rtl/skh_hash.sv]
// ----------------------------------------------------------------------------
// skh_hash
// DJB2 hash accumulator: hash = hash * 33 + signed byte, 64-bit wrap.
// ----------------------------------------------------------------------------
module skh_hash (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        step_i,
  input  logic        clear_i,
  input  logic [7:0]  byte_i,
  output logic [63:0] next_o
);

  logic [63:0] hash_q;

  // Multiply by 33 is a shift and an add.
  assign next_o = (hash_q << 5) + hash_q + {{56{byte_i[7]}}, byte_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_q <= skh_pkg::HashSeed;
    end else if (clear_i) begin
      hash_q <= skh_pkg::HashSeed;
    end else if (step_i) begin
      hash_q <= next_o;
    end
  end

endmodule

[rtl/skh_mem.sv]
// ----------------------------------------------------------------------------
// skh_mem
// Generic single port synchronous memory with a registered read.
// ----------------------------------------------------------------------------
module skh_mem #(
  parameter int unsigned Depth = 1024,
  parameter int unsigned Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // Write first is not needed: the read data of a write cycle is never used.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[addr_i] <= wdata_i;
    end
    rdata_o <= mem[addr_i];
  end

endmodule

[test/tb_string_key_hash_table_probe.sv]
// ----------------------------------------------------------------------------
// tb_string_key_hash_table_probe
// Self-checking testbench: streams keys into the hash table, predicts each
// result with a behavioral table model and compares the outputs field by field.
// ----------------------------------------------------------------------------
module tb_string_key_hash_table_probe;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned WatchdogLimit = 400000;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_stall_o;
  skh_pkg::in_item_t  in_data_i;
  logic               out_valid_o;
  logic               out_stall_i;
  skh_pkg::out_item_t out_data_o;

  string_key_hash_table_probe dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  // Table model state.
  bit          tbl_used  [skh_pkg::TableEntries];
  logic [7:0]  tbl_key   [skh_pkg::TableEntries][skh_pkg::KeyBytes];
  int unsigned tbl_len   [skh_pkg::TableEntries];
  logic [19:0] tbl_start [skh_pkg::TableEntries];
  logic [19:0] tbl_count [skh_pkg::TableEntries];
  logic [7:0]  cur_key   [skh_pkg::KeyBytes];
  int unsigned cur_len;
  logic [63:0] cur_hash;
  bit          cur_overflow;

  skh_pkg::in_item_t  byte_queue[$];
  skh_pkg::out_item_t expected_results[$];
  int unsigned error_count;
  int unsigned idle_cycles;
  bit          stim_done;

  // Stored keys used to generate hits on find.
  logic [7:0]  known_keys[$][$];

  // Advance the table model by one key byte and queue any result.
  task automatic predict_byte(input skh_pkg::in_item_t it);
    logic [63:0] addend;
    int unsigned idx;
    int unsigned n;
    bit          hit;
    skh_pkg::out_item_t res;
    addend = {{56{it.key_byte[7]}}, it.key_byte};
    cur_hash = cur_hash * 64'd33 + addend;
    if (cur_len < skh_pkg::KeyBytes) begin
      cur_key[cur_len] = it.key_byte;
      cur_len++;
    end else begin
      cur_overflow = 1'b1;
    end
    if (!it.key_last) return;
    res = '0;
    idx = 32'(cur_hash % 64'(skh_pkg::TableEntries));
    if (cur_overflow) begin
      res.status = skh_pkg::StTooLong;
    end else if (it.action == 1'b0) begin
      res.status = skh_pkg::StFull;
      for (n = 0; n < skh_pkg::TableEntries; n++) begin
        if (!tbl_used[idx]) begin
          for (int k = 0; k < skh_pkg::KeyBytes; k++) begin
            tbl_key[idx][k] = (k < cur_len) ? cur_key[k] : 8'd0;
          end
          tbl_len[idx]   = cur_len;
          tbl_start[idx] = it.rec_start;
          tbl_count[idx] = it.group_count;
          tbl_used[idx]  = 1'b1;
          res.status = skh_pkg::StInserted;
          res.slot   = idx[9:0];
          break;
        end
        idx = (idx + 1) % skh_pkg::TableEntries;
      end
    end else begin
      res.status = skh_pkg::StNotFound;
      for (n = 0; n < skh_pkg::TableEntries && tbl_used[idx]; n++) begin
        hit = (tbl_len[idx] == cur_len);
        for (int k = 0; k < cur_len && hit; k++) if (tbl_key[idx][k] !== cur_key[k]) hit = 0;
        if (hit) begin
          res.status      = skh_pkg::StFound;
          res.found_start = tbl_start[idx];
          res.found_count = tbl_count[idx];
          res.slot        = idx[9:0];
          break;
        end
        idx = (idx + 1) % skh_pkg::TableEntries;
      end
    end
    expected_results.push_back(res);
    cur_len = 0;
    cur_hash = skh_pkg::HashSeed;
    cur_overflow = 1'b0;
  endtask

  // Queue one key as a sequence of byte transactions.
  task automatic add_key(input logic [7:0] kb[$], input bit act, input logic [19:0] si,
                         input logic [19:0] gc);
    skh_pkg::in_item_t it;
    foreach (kb[k]) begin
      it.action      = (k == kb.size() - 1) ? act : 1'($urandom);
      it.key_byte    = kb[k];
      it.key_last    = (k == kb.size() - 1);
      it.rec_start   = it.key_last ? si : 20'($urandom);
      it.group_count = it.key_last ? gc : 20'($urandom);
      byte_queue.push_back(it);
    end
    if (act == 1'b0 && kb.size() <= skh_pkg::KeyBytes) known_keys.push_back(kb);
  endtask

  function automatic void random_key(output logic [7:0] kb[$], input int unsigned len,
                                     input bit narrow);
    kb = {};
    for (int k = 0; k < len; k++) kb.push_back(narrow ? 8'($urandom_range(97, 100)) : 8'($urandom));
  endfunction

  // Clock.
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  // Input driver: presents queued bytes with random gaps.
  int unsigned in_gap;
  bit          in_taken;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (in_taken) begin
        // Accepted at the last rising edge.
        void'(byte_queue.pop_front());
        in_gap = gap_len();
      end
      if (in_valid_i && !in_taken) begin
        // Hold the stalled transaction.
      end else if (in_gap > 0) begin
        in_gap--;
        in_valid_i <= 1'b0;
      end else if (byte_queue.size() > 0) begin
        in_valid_i <= 1'b1;
        in_data_i  <= byte_queue[0];
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output stall generator.
  int unsigned out_hold;
  bit          stall_phase;
  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_hold > 0) begin
        out_hold--;
      end else begin
        stall_phase = !stall_phase;
        out_hold = stall_phase ? gap_len() : $urandom_range(0, 12);
        out_stall_i <= stall_phase && (out_hold > 0);
      end
    end
  end

  // Monitor: predicts on accepted input, checks accepted results.
  always @(posedge clk_i) begin
    in_taken = in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_taken || (out_valid_o && !out_stall_i)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (in_taken) begin
        predict_byte(in_data_i);
      end
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result %p", $realtime, out_data_o);
          error_count++;
        end else begin
          skh_pkg::out_item_t exp_res;
          exp_res = expected_results.pop_front();
          if (out_data_o.status !== exp_res.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, exp_res.status,
                     out_data_o.status);
            error_count++;
          end
          if (out_data_o.found_start !== exp_res.found_start) begin
            $display("%0t: found_start expected %0h actual %0h", $realtime,
                     exp_res.found_start, out_data_o.found_start);
            error_count++;
          end
          if (out_data_o.found_count !== exp_res.found_count) begin
            $display("%0t: found_count expected %0h actual %0h", $realtime,
                     exp_res.found_count, out_data_o.found_count);
            error_count++;
          end
          if (out_data_o.slot !== exp_res.slot) begin
            $display("%0t: slot expected %0d actual %0d", $realtime, exp_res.slot,
                     out_data_o.slot);
            error_count++;
          end
        end
      end
    end
  end

  // Watchdog on cycles without any transaction.
  always @(posedge clk_i) begin
    if (rst_ni && idle_cycles >= WatchdogLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Stimulus and end of run.
  initial begin
    logic [7:0] kb[$];
    int unsigned pick;
    int unsigned tail;
    rst_ni       = 1'b0;
    in_valid_i   = 1'b0;
    in_data_i    = '0;
    out_stall_i  = 1'b0;
    in_gap       = 0;
    in_taken     = 1'b0;
    out_hold     = 0;
    stall_phase  = 0;
    error_count  = 0;
    idle_cycles  = 0;
    cur_len      = 0;
    cur_hash     = skh_pkg::HashSeed;
    cur_overflow = 1'b0;
    foreach (tbl_used[s]) tbl_used[s] = 1'b0;

    // Directed keys: extremes, zero bytes, sign-extended bytes, duplicates.
    add_key({8'h41}, 1'b1, 20'd0, 20'd0);
    add_key({8'h41}, 1'b0, 20'hFFFFF, 20'hFFFFF);
    add_key({8'h41}, 1'b1, 20'd0, 20'd0);
    add_key({8'h00}, 1'b0, 20'd0, 20'd0);
    add_key({8'h00}, 1'b1, 20'd5, 20'd5);
    add_key({8'h00, 8'h00}, 1'b1, 20'd0, 20'd0);
    add_key({8'hFF, 8'h80, 8'h7F}, 1'b0, 20'h12345, 20'h6789A);
    add_key({8'hFF, 8'h80, 8'h7F}, 1'b1, 20'd0, 20'd0);
    add_key({8'h41}, 1'b0, 20'h00001, 20'h00002);
    add_key({8'h41}, 1'b1, 20'd0, 20'd0);
    random_key(kb, skh_pkg::KeyBytes, 0);
    add_key(kb, 1'b0, 20'hAAAAA, 20'h55555);
    add_key(kb, 1'b1, 20'd0, 20'd0);
    random_key(kb, skh_pkg::KeyBytes + 1, 0);
    add_key(kb, 1'b0, 20'd1, 20'd1);
    random_key(kb, skh_pkg::KeyBytes + 3, 0);
    add_key(kb, 1'b1, 20'd1, 20'd1);

    // Random keys: mostly inserts and finds of short keys, some long ones.
    while (byte_queue.size() < 650 && known_keys.size() < 300) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        random_key(kb, $urandom_range(1, 6), 1'($urandom_range(0, 1)));
        add_key(kb, 1'b0, 20'($urandom), 20'($urandom));
      end else if (pick < 75 && known_keys.size() > 0) begin
        add_key(known_keys[$urandom_range(0, known_keys.size() - 1)], 1'b1, 20'($urandom),
                20'($urandom));
      end else if (pick < 93) begin
        random_key(kb, $urandom_range(1, 4), 1'($urandom_range(0, 1)));
        add_key(kb, 1'b1, 20'($urandom), 20'($urandom));
      end else begin
        random_key(kb, $urandom_range(skh_pkg::KeyBytes - 2, skh_pkg::KeyBytes + 4), 0);
        add_key(kb, 1'($urandom_range(0, 1)), 20'($urandom), 20'($urandom));
      end
    end

    // Fill the table completely, then hit it full with inserts and finds.
    while (known_keys.size() < skh_pkg::TableEntries + 4) begin
      random_key(kb, 1, 0);
      add_key(kb, 1'b0, 20'($urandom), 20'($urandom));
    end
    random_key(kb, 2, 0);
    add_key(kb, 1'b1, 20'd0, 20'd0);
    add_key(known_keys[$urandom_range(0, 50)], 1'b1, 20'd0, 20'd0);
    add_key({8'h5A}, 1'b0, 20'd1, 20'd1);

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    wait (byte_queue.size() == 0 && !in_valid_i);
    wait (expected_results.size() == 0);
    tail = 0;
    while (tail < 3000) begin
      @(posedge clk_i);
      tail++;
    end
    if (error_count == 0 && expected_results.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

[string_key_hash_table_probe.f]
+incdir+rtl
rtl/skh_pkg.sv
rtl/skh_hash.sv
rtl/skh_mem.sv
rtl/string_key_hash_table_probe.sv
test/tb_string_key_hash_table_probe.sv
